FILE: sv/tlc_pkg.sv
package tlc_pkg;

    // tag width of one cache line, both levels
    localparam int TAG_W = 64;

    // configuration register indexes
    localparam logic [2:0] CFG_BLOCK_LOG2   = 3'd0;
    localparam logic [2:0] CFG_L1_SIZE_LOG2 = 3'd1;
    localparam logic [2:0] CFG_L1_WAYS_LOG2 = 3'd2;
    localparam logic [2:0] CFG_L2_SIZE_LOG2 = 3'd3;
    localparam logic [2:0] CFG_L2_WAYS_LOG2 = 3'd4;
    localparam logic [2:0] CFG_COUNT        = 3'd5;

    // configuration reset values
    localparam logic [2:0] RST_BLOCK_LOG2   = 3'd6;
    localparam logic [4:0] RST_L1_SIZE_LOG2 = 5'd13;
    localparam logic [1:0] RST_L1_WAYS_LOG2 = 2'd1;
    localparam logic [4:0] RST_L2_SIZE_LOG2 = 5'd15;
    localparam logic [1:0] RST_L2_WAYS_LOG2 = 2'd2;

    typedef enum logic [1:0] {
        U_NOP,
        U_LOOKUP,
        U_COMMIT,
        U_CLEAR
    } unit_op_t;

    typedef struct packed {
        unit_op_t op;
        logic     touch;
        logic     set_dirty;
        logic     fill_dirty;
    } unit_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             hit;
        logic             victim_dirty;
        logic [TAG_W-1:0] victim_tag;
    } unit_stat_t;

    typedef enum logic [2:0] {
        US_IDLE,
        US_SCAN,
        US_SCAN_LAST,
        US_COMMIT,
        US_CLEAR
    } unit_state_t;

    typedef enum logic [3:0] {
        T_CLEAR,
        T_IDLE,
        T_CALC,
        T_L1_LOOK,
        T_L1_HIT,
        T_L2_LOOK,
        T_L2_COMMIT,
        T_L1_FILL,
        T_VCALC1,
        T_VCALC2,
        T_V_LOOK,
        T_V_COMMIT,
        T_DONE
    } top_state_t;

endpackage

FILE: sv/tlc_set_unit.sv
module tlc_set_unit #(
    parameter int LINES_LOG2 = 10,
    parameter int WAYS_LOG2  = 3,
    localparam int AW = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tlc_pkg::unit_cmd_t           cmd,
    input  logic [LINES_LOG2-1:0]        base,
    input  logic [tlc_pkg::TAG_W-1:0]    tag,
    input  logic [AW-1:0]                way_mask,
    output tlc_pkg::unit_stat_t          stat
);
    import tlc_pkg::*;

    localparam int EW    = TAG_W + 2 + AW;
    localparam int DEPTH = 2 ** LINES_LOG2;
    localparam int NBUF  = 2 ** AW;

    // entry layout: {tag, valid, dirty, age}
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_reg;
    logic [EW-1:0] set_buf_reg [NBUF];

    logic                  mem_we;
    logic [LINES_LOG2-1:0] mem_addr;
    logic [EW-1:0]         mem_wdata;

    unit_state_t ustate_reg, ustate_next;
    logic [LINES_LOG2-1:0] cnt_reg, cnt_next;
    logic          p_vld_reg, p_vld_next;
    logic [AW-1:0] p_way_reg, p_way_next;

    logic          hit_f_reg, hit_f_next;
    logic [AW-1:0] hit_way_reg, hit_way_next;
    logic [AW-1:0] hit_age_reg, hit_age_next;
    logic          hit_dirty_reg, hit_dirty_next;
    logic          inv_f_reg, inv_f_next;
    logic [AW-1:0] inv_way_reg, inv_way_next;
    logic [AW-1:0] inv_age_reg, inv_age_next;
    logic          a0_f_reg, a0_f_next;
    logic [AW-1:0] a0_way_reg, a0_way_next;
    logic          a0_dirty_reg, a0_dirty_next;
    logic [TAG_W-1:0] a0_tag_reg, a0_tag_next;
    logic          w0_dirty_reg, w0_dirty_next;
    logic [TAG_W-1:0] w0_tag_reg, w0_tag_next;
    logic [AW-1:0] w0_age_reg, w0_age_next;
    logic touch_reg, touch_next;
    logic set_reg, set_next;
    logic fill_reg, fill_next;

    logic [TAG_W-1:0] e_tag;
    logic             e_valid;
    logic             e_dirty;
    logic [AW-1:0]    e_age;

    logic [AW-1:0]    vic_way;
    logic [AW-1:0]    vic_age;
    logic             vic_dirty;
    logic [TAG_W-1:0] vic_tag;
    logic [AW-1:0]    tgt_way;
    logic [AW-1:0]    cur_age;
    logic             new_dirty;
    logic [AW-1:0]    cw;
    logic [EW-1:0]    old_e;
    logic [AW-1:0]    old_age;

    assign e_tag   = rd_reg[EW-1 -: TAG_W];
    assign e_valid = rd_reg[AW+1];
    assign e_dirty = rd_reg[AW];
    assign e_age   = rd_reg[AW-1:0];

    // victim: first invalid way, else first age-0 way, else way 0
    assign vic_way   = inv_f_reg ? inv_way_reg : (a0_f_reg ? a0_way_reg : '0);
    assign vic_age   = inv_f_reg ? inv_age_reg : (a0_f_reg ? '0 : w0_age_reg);
    assign vic_dirty = !inv_f_reg && (a0_f_reg ? a0_dirty_reg : w0_dirty_reg);
    assign vic_tag   = a0_f_reg ? a0_tag_reg : w0_tag_reg;
    assign tgt_way   = hit_f_reg ? hit_way_reg : vic_way;
    assign cur_age   = hit_f_reg ? hit_age_reg : vic_age;
    assign new_dirty = hit_f_reg ? (hit_dirty_reg | set_reg) : fill_reg;

    assign cw      = cnt_reg[AW-1:0];
    assign old_e   = set_buf_reg[cw];
    assign old_age = old_e[AW-1:0];

    assign stat.busy         = (ustate_reg != US_IDLE);
    assign stat.hit          = hit_f_reg;
    assign stat.victim_dirty = vic_dirty;
    assign stat.victim_tag   = vic_tag;

    always_comb
    begin
        ustate_next    = ustate_reg;
        cnt_next       = cnt_reg;
        p_vld_next     = 1'b0;
        p_way_next     = p_way_reg;
        hit_f_next     = hit_f_reg;
        hit_way_next   = hit_way_reg;
        hit_age_next   = hit_age_reg;
        hit_dirty_next = hit_dirty_reg;
        inv_f_next     = inv_f_reg;
        inv_way_next   = inv_way_reg;
        inv_age_next   = inv_age_reg;
        a0_f_next      = a0_f_reg;
        a0_way_next    = a0_way_reg;
        a0_dirty_next  = a0_dirty_reg;
        a0_tag_next    = a0_tag_reg;
        w0_dirty_next  = w0_dirty_reg;
        w0_tag_next    = w0_tag_reg;
        w0_age_next    = w0_age_reg;
        touch_next     = touch_reg;
        set_next       = set_reg;
        fill_next      = fill_reg;
        mem_we         = 1'b0;
        mem_addr       = base | LINES_LOG2'(cw);
        mem_wdata      = '0;

        case (ustate_reg)
            US_SCAN:
            begin
                p_vld_next = 1'b1;
                p_way_next = cw;
                cnt_next   = cnt_reg + 1'b1;
                if (cw == way_mask)
                    ustate_next = US_SCAN_LAST;
            end
            US_SCAN_LAST:
                ustate_next = US_IDLE;
            US_COMMIT:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cw == tgt_way)
                    mem_wdata = {tag, 1'b1, new_dirty, touch_reg ? way_mask : cur_age};
                else if (touch_reg && old_age > cur_age)
                    mem_wdata = {old_e[EW-1:AW], old_age - 1'b1};
                else
                    mem_wdata = old_e;
                if (cw == way_mask)
                    ustate_next = US_IDLE;
            end
            US_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = cnt_reg;
                mem_wdata = {{TAG_W{1'b0}}, 1'b0, 1'b0, cw & way_mask};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    ustate_next = US_IDLE;
            end
            default:
                ;
        endcase

        // one returned way per cycle
        if (p_vld_reg)
        begin
            if (e_valid && e_tag == tag && !hit_f_reg)
            begin
                hit_f_next     = 1'b1;
                hit_way_next   = p_way_reg;
                hit_age_next   = e_age;
                hit_dirty_next = e_dirty;
            end
            if (!e_valid && !inv_f_reg)
            begin
                inv_f_next   = 1'b1;
                inv_way_next = p_way_reg;
                inv_age_next = e_age;
            end
            if (e_age == '0 && !a0_f_reg)
            begin
                a0_f_next     = 1'b1;
                a0_way_next   = p_way_reg;
                a0_dirty_next = e_dirty;
                a0_tag_next   = e_tag;
            end
            if (p_way_reg == '0)
            begin
                w0_dirty_next = e_dirty;
                w0_tag_next   = e_tag;
                w0_age_next   = e_age;
            end
        end

        case (cmd.op)
            U_LOOKUP:
            begin
                ustate_next = US_SCAN;
                cnt_next    = '0;
                hit_f_next  = 1'b0;
                inv_f_next  = 1'b0;
                a0_f_next   = 1'b0;
            end
            U_COMMIT:
            begin
                ustate_next = US_COMMIT;
                cnt_next    = '0;
                touch_next  = cmd.touch;
                set_next    = cmd.set_dirty;
                fill_next   = cmd.fill_dirty;
            end
            U_CLEAR:
            begin
                ustate_next = US_CLEAR;
                cnt_next    = '0;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_reg <= mem[mem_addr];
        if (p_vld_reg)
            set_buf_reg[p_way_reg] <= rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ustate_reg <= US_IDLE;
            cnt_reg    <= '0;
            p_vld_reg  <= 1'b0;
            hit_f_reg  <= 1'b0;
            inv_f_reg  <= 1'b0;
            a0_f_reg   <= 1'b0;
            touch_reg  <= 1'b0;
            set_reg    <= 1'b0;
            fill_reg   <= 1'b0;
        end
        else
        begin
            ustate_reg <= ustate_next;
            cnt_reg    <= cnt_next;
            p_vld_reg  <= p_vld_next;
            hit_f_reg  <= hit_f_next;
            inv_f_reg  <= inv_f_next;
            a0_f_reg   <= a0_f_next;
            touch_reg  <= touch_next;
            set_reg    <= set_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_way_reg     <= p_way_next;
        hit_way_reg   <= hit_way_next;
        hit_age_reg   <= hit_age_next;
        hit_dirty_reg <= hit_dirty_next;
        inv_way_reg   <= inv_way_next;
        inv_age_reg   <= inv_age_next;
        a0_way_reg    <= a0_way_next;
        a0_dirty_reg  <= a0_dirty_next;
        a0_tag_reg    <= a0_tag_next;
        w0_dirty_reg  <= w0_dirty_next;
        w0_tag_reg    <= w0_tag_next;
        w0_age_reg    <= w0_age_next;
    end

endmodule

FILE: sv/two_level_lru_cache_tags_top.sv
// channel   dir  signals                        word contents (lsb first)
// s         in   s_tvalid s_tready s_tdata s_tuser   address[63:0] / is_write
// m         out  m_tvalid m_tready m_tdata           l1_hit, l2_hit, writebacks[1:0]
// cfg       in   cfg_we cfg_index cfg_data           register index / value
//
// one access word at a time; each set pass reads or writes one way per cycle
// after reset and after every register write the block sweeps its rams and takes no
// access word meanwhile
// a finished result sits in the output register, a new word is taken behind it
module two_level_lru_cache_tags_top #(
    parameter int L1_LINES_LOG2 = 10,
    parameter int L2_LINES_LOG2 = 14,
    parameter int MAX_WAYS_LOG2 = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // address
    input  logic        s_tuser,     // is_write
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // l1_hit, l2_hit, writebacks[1:0], zero pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import tlc_pkg::*;

    localparam int AW  = (MAX_WAYS_LOG2 > 0) ? MAX_WAYS_LOG2 : 1;
    localparam int WLW = (MAX_WAYS_LOG2 > 0) ? $clog2(MAX_WAYS_LOG2 + 1) : 1;

    // configuration
    logic [2:0] blk_reg;
    logic [4:0] l1_size_reg;
    logic [1:0] l1_ways_reg;
    logic [4:0] l2_size_reg;
    logic [1:0] l2_ways_reg;
    logic       cfg_hit;

    // geometry derived from the registers
    logic [WLW-1:0]           w1, w2;
    logic [5:0]               sh1, sh2;
    logic [L1_LINES_LOG2-1:0] set_mask1;
    logic [L2_LINES_LOG2-1:0] set_mask2;
    logic [AW-1:0]            way_mask1, way_mask2;

    // per-access datapath
    logic [63:0]              addr_reg;
    logic                     wr_reg;
    logic [TAG_W-1:0]         t1_reg, t2_reg, vt_reg;
    logic [L1_LINES_LOG2-1:0] set1_reg, base1_reg;
    logic [L2_LINES_LOG2-1:0] base2_reg, vb_reg;
    logic [63:0]              vaddr_reg;

    top_state_t state_reg, state_next;
    logic       issued_reg, issued_next;
    logic       l1h_reg, l1h_next;
    logic       l2h_reg, l2h_next;
    logic [1:0] wb_reg, wb_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_load;

    unit_cmd_t  l1_cmd, l2_cmd;
    unit_stat_t l1_stat, l2_stat;
    logic [L2_LINES_LOG2-1:0] l2_base;
    logic [TAG_W-1:0]         l2_tag;

    assign s_tready = (state_reg == T_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign cfg_hit  = cfg_we && (cfg_index < CFG_COUNT);

    always_comb
    begin
        int wi1, ni1, wi2, ni2;
        wi1 = int'(l1_ways_reg);
        if (wi1 > MAX_WAYS_LOG2) wi1 = MAX_WAYS_LOG2;
        if (wi1 > L1_LINES_LOG2) wi1 = L1_LINES_LOG2;
        ni1 = (l1_size_reg >= 5'(blk_reg)) ? int'(l1_size_reg) - int'(blk_reg) : 0;
        if (ni1 < wi1) ni1 = wi1;
        if (ni1 > L1_LINES_LOG2) ni1 = L1_LINES_LOG2;
        wi2 = int'(l2_ways_reg);
        if (wi2 > MAX_WAYS_LOG2) wi2 = MAX_WAYS_LOG2;
        if (wi2 > L2_LINES_LOG2) wi2 = L2_LINES_LOG2;
        ni2 = (l2_size_reg >= 5'(blk_reg)) ? int'(l2_size_reg) - int'(blk_reg) : 0;
        if (ni2 < wi2) ni2 = wi2;
        if (ni2 > L2_LINES_LOG2) ni2 = L2_LINES_LOG2;
        w1        = WLW'(wi1);
        w2        = WLW'(wi2);
        sh1       = 6'(int'(blk_reg) + ni1 - wi1);
        sh2       = 6'(int'(blk_reg) + ni2 - wi2);
        set_mask1 = L1_LINES_LOG2'((1 << (ni1 - wi1)) - 1);
        set_mask2 = L2_LINES_LOG2'((1 << (ni2 - wi2)) - 1);
        way_mask1 = AW'((1 << wi1) - 1);
        way_mask2 = AW'((1 << wi2) - 1);
    end

    // the l2 ram serves both the access block and the l1 victim block
    assign l2_base = (state_reg inside {T_V_LOOK, T_V_COMMIT}) ? vb_reg : base2_reg;
    assign l2_tag  = (state_reg inside {T_V_LOOK, T_V_COMMIT}) ? vt_reg : t2_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        l1h_next       = l1h_reg;
        l2h_next       = l2h_reg;
        wb_next        = wb_reg;
        out_load       = 1'b0;
        l1_cmd         = '{op: U_NOP, touch: 1'b1, set_dirty: wr_reg, fill_dirty: wr_reg};
        l2_cmd         = '{op: U_NOP, touch: 1'b1, set_dirty: 1'b0, fill_dirty: 1'b0};

        case (state_reg)
            T_CLEAR:
                if (!issued_reg)
                begin
                    l1_cmd.op   = U_CLEAR;
                    l2_cmd.op   = U_CLEAR;
                    issued_next = 1'b1;
                end
                else if (!l1_stat.busy && !l2_stat.busy)
                begin
                    issued_next = 1'b0;
                    state_next  = T_IDLE;
                end
            T_IDLE:
                if (s_tvalid)
                begin
                    state_next = T_CALC;
                    l1h_next   = 1'b0;
                    l2h_next   = 1'b0;
                    wb_next    = '0;
                end
            T_CALC:
                state_next = T_L1_LOOK;
            T_L1_LOOK:
                if (!issued_reg)
                begin
                    l1_cmd.op   = U_LOOKUP;
                    issued_next = 1'b1;
                end
                else if (!l1_stat.busy)
                begin
                    issued_next = 1'b0;
                    l1h_next    = l1_stat.hit;
                    state_next  = l1_stat.hit ? T_L1_HIT : T_L2_LOOK;
                end
            T_L1_HIT, T_L1_FILL:
                if (!issued_reg)
                begin
                    l1_cmd.op   = U_COMMIT;
                    issued_next = 1'b1;
                end
                else if (!l1_stat.busy)
                begin
                    issued_next = 1'b0;
                    if (state_reg == T_L1_FILL && l1_stat.victim_dirty)
                        state_next = T_VCALC1;
                    else
                        state_next = T_DONE;
                end
            T_L2_LOOK, T_V_LOOK:
                if (!issued_reg)
                begin
                    l2_cmd.op   = U_LOOKUP;
                    issued_next = 1'b1;
                end
                else if (!l2_stat.busy)
                begin
                    issued_next = 1'b0;
                    if (state_reg == T_L2_LOOK)
                    begin
                        l2h_next   = l2_stat.hit;
                        state_next = T_L2_COMMIT;
                    end
                    else
                        state_next = T_V_COMMIT;
                end
            T_L2_COMMIT:
                if (!issued_reg)
                begin
                    l2_cmd.op   = U_COMMIT;
                    issued_next = 1'b1;
                end
                else if (!l2_stat.busy)
                begin
                    issued_next = 1'b0;
                    // l2 victim evicted dirty
                    if (!l2_stat.hit && l2_stat.victim_dirty)
                        wb_next = wb_reg + 2'd1;
                    state_next = T_L1_FILL;
                end
            T_VCALC1:
                state_next = T_VCALC2;
            T_VCALC2:
                state_next = T_V_LOOK;
            T_V_COMMIT:
            begin
                // victim copy marked dirty on a hit, placed clean on a miss; no aging either way
                l2_cmd.touch     = 1'b0;
                l2_cmd.set_dirty = 1'b1;
                if (!issued_reg)
                begin
                    l2_cmd.op   = U_COMMIT;
                    issued_next = 1'b1;
                end
                else if (!l2_stat.busy)
                begin
                    issued_next = 1'b0;
                    if (!l2_stat.hit)
                        wb_next = wb_reg + 2'd1 + 2'(l2_stat.victim_dirty);
                    state_next = T_DONE;
                end
            end
            T_DONE:
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = T_IDLE;
                end
            default:
                state_next = T_CLEAR;
        endcase

        // any register write rebuilds both caches
        if (cfg_hit)
        begin
            state_next  = T_CLEAR;
            issued_next = 1'b0;
        end
    end

    assign out_valid_next = (out_valid_reg && !m_tready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_CLEAR;
            issued_reg    <= 1'b0;
            l1h_reg       <= 1'b0;
            l2h_reg       <= 1'b0;
            wb_reg        <= '0;
            out_valid_reg <= 1'b0;
            blk_reg       <= RST_BLOCK_LOG2;
            l1_size_reg   <= RST_L1_SIZE_LOG2;
            l1_ways_reg   <= RST_L1_WAYS_LOG2;
            l2_size_reg   <= RST_L2_SIZE_LOG2;
            l2_ways_reg   <= RST_L2_WAYS_LOG2;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            l1h_reg       <= l1h_next;
            l2h_reg       <= l2h_next;
            wb_reg        <= wb_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BLOCK_LOG2:   blk_reg     <= cfg_data[2:0];
                    CFG_L1_SIZE_LOG2: l1_size_reg <= cfg_data;
                    CFG_L1_WAYS_LOG2: l1_ways_reg <= cfg_data[1:0];
                    CFG_L2_SIZE_LOG2: l2_size_reg <= cfg_data;
                    CFG_L2_WAYS_LOG2: l2_ways_reg <= cfg_data[1:0];
                    default:          ;
                endcase
            end
        end
    end

    // address split and victim address rebuild
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            addr_reg <= s_tdata;
            wr_reg   <= s_tuser;
        end
        if (state_reg == T_CALC)
        begin
            t1_reg    <= addr_reg >> sh1;
            t2_reg    <= addr_reg >> sh2;
            set1_reg  <= L1_LINES_LOG2'(addr_reg >> blk_reg) & set_mask1;
            base1_reg <= (L1_LINES_LOG2'(addr_reg >> blk_reg) & set_mask1) << w1;
            base2_reg <= (L2_LINES_LOG2'(addr_reg >> blk_reg) & set_mask2) << w2;
        end
        if (state_reg == T_VCALC1)
            vaddr_reg <= (l1_stat.victim_tag << sh1) | (64'(set1_reg) << blk_reg);
        if (state_reg == T_VCALC2)
        begin
            vt_reg <= vaddr_reg >> sh2;
            vb_reg <= (L2_LINES_LOG2'(vaddr_reg >> blk_reg) & set_mask2) << w2;
        end
        if (out_load)
            out_data_reg <= {4'b0000, wb_reg, l2h_reg, l1h_reg};
    end

    tlc_set_unit #(
        .LINES_LOG2 (L1_LINES_LOG2),
        .WAYS_LOG2  (MAX_WAYS_LOG2)
    ) u_l1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (l1_cmd),
        .base     (base1_reg),
        .tag      (t1_reg),
        .way_mask (way_mask1),
        .stat     (l1_stat)
    );

    tlc_set_unit #(
        .LINES_LOG2 (L2_LINES_LOG2),
        .WAYS_LOG2  (MAX_WAYS_LOG2)
    ) u_l2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (l2_cmd),
        .base     (l2_base),
        .tag      (l2_tag),
        .way_mask (way_mask2),
        .stat     (l2_stat)
    );

    // an l1 hit causes no write-back
    a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[3:2] != 2'd0))
        else $error("write-back reported on an l1 hit");

    // both hit flags never set together
    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("l1 and l2 hit both set");

    // a register write always restarts the ram sweep
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (state_reg == T_CLEAR && !issued_reg))
        else $error("register write did not restart the sweep");

    // no access word taken while the sweep runs
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_CLEAR) |-> !s_tready)
        else $error("access taken during sweep");

endmodule
